@@ hdl/per_sender_sequence_loss_tracker_top_assert.svh @@
// Assertion macros shared by the loss tracker RTL.
// Included by the table and the top level; needs clk and rst_n in scope.
`ifndef PER_SENDER_SEQUENCE_LOSS_TRACKER_TOP_ASSERT_SVH
`define PER_SENDER_SEQUENCE_LOSS_TRACKER_TOP_ASSERT_SVH

`ifndef SYNTHESIS
// Check that a condition holds at every clock edge outside reset.
`define PSLT_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);
// Check that a trigger is followed by a result on the next clock edge.
`define PSLT_ASSERT_NEXT(label, trig, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
        else $error(msg);
`else
`define PSLT_ASSERT_ALWAYS(label, cond, msg)
`define PSLT_ASSERT_NEXT(label, trig, cons, msg)
`endif

`endif

@@ hdl/pslt_pkg.sv @@
// Shared types and constants of the per-sender sequence loss tracker.
// No dependencies; used by the interfaces, the table and the top level.
package pslt_pkg;

    // Field widths
    localparam int ID_W   = 8;
    localparam int SEQ_W  = 16;
    localparam int TIME_W = 64;
    localparam int CNT_W  = 32;
    localparam int MISS_W = 16;
    localparam int CLS_W  = 3;

    // Default table depth
    localparam int SENDERS_DEF = 256;

    // Sequence difference thresholds (difference is 18-bit signed)
    localparam int DIFF_W = SEQ_W + 2;
    localparam logic signed [DIFF_W-1:0] ROLL_LIMIT    = -18'sd32768;
    localparam logic signed [DIFF_W-1:0] RESTART_LIMIT = -18'sd20;
    localparam logic signed [DIFF_W-1:0] DIFF_DUP      = -18'sd1;

    // Gap classes
    typedef enum logic [CLS_W-1:0] {
        CLS_FIRST   = 3'd0,
        CLS_INORDER = 3'd1,
        CLS_GAP     = 3'd2,
        CLS_DUP     = 3'd3,
        CLS_ROLL    = 3'd4,
        CLS_RESTART = 3'd5,
        CLS_OOO     = 3'd6
    } gap_class_t;

    // One per-sender table entry
    typedef struct packed {
        logic [CNT_W-1:0]  rcv;
        logic [CNT_W-1:0]  sent;
        logic [SEQ_W-1:0]  last_seq;
        logic [MISS_W-1:0] missed;
        logic [SEQ_W-1:0]  seq_start;
        logic [TIME_W-1:0] last_arrival;
    } entry_t;

    // Table access control
    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } tbl_ctl_t;

endpackage

@@ hdl/pslt_ifs.sv @@
// Valid/ready channel interfaces for packets in and results out.
// Depends on pslt_pkg for field widths.
interface pslt_in_if
    import pslt_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [ID_W-1:0]   sender_id;
    logic [SEQ_W-1:0]  seq_num;
    logic              has_stamp;
    logic [TIME_W-1:0] sent_time_us;
    logic [TIME_W-1:0] arrival_time_us;

    modport source (output valid, sender_id, seq_num, has_stamp, sent_time_us,
                    arrival_time_us, input ready);
    modport sink   (input valid, sender_id, seq_num, has_stamp, sent_time_us,
                    arrival_time_us, output ready);
endinterface

interface pslt_out_if
    import pslt_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic [CLS_W-1:0]         gap_class;
    logic [MISS_W-1:0]        missed_now;
    logic [MISS_W-1:0]        sender_missed;
    logic [CNT_W-1:0]         sender_sent;
    logic [CNT_W-1:0]         sender_received;
    logic [CNT_W-1:0]         total_missed;
    logic                     latency_valid;
    logic signed [TIME_W-1:0] latency_us;
    logic                     interval_valid;
    logic [TIME_W-1:0]        interval_us;

    modport source (output valid, gap_class, missed_now, sender_missed, sender_sent,
                    sender_received, total_missed, latency_valid, latency_us,
                    interval_valid, interval_us, input ready);
    modport sink   (input valid, gap_class, missed_now, sender_missed, sender_sent,
                    sender_received, total_missed, latency_valid, latency_us,
                    interval_valid, interval_us, output ready);
endinterface

@@ hdl/pslt_table.sv @@
// Per-sender state table: synchronous memory with a registered read,
// plus per-entry valid bits so unwritten entries read as zero.
// Depends on pslt_pkg and the assertion macro header.
`include "per_sender_sequence_loss_tracker_top_assert.svh"

module pslt_table
    import pslt_pkg::*;
#(
    parameter int SENDERS = SENDERS_DEF,
    localparam int IDX_W  = (SENDERS > 1) ? $clog2(SENDERS) : 1
) (
    input  logic             clk,
    input  logic             rst_n,
    input  tbl_ctl_t         ctl,
    input  logic [IDX_W-1:0] rd_addr,
    input  logic [IDX_W-1:0] wr_addr,
    input  entry_t           wr_data,
    output entry_t           rd_data
);

    entry_t             mem [SENDERS];
    entry_t             rd_data_reg;
    logic               rd_valid_reg;
    logic [SENDERS-1:0] valid_reg;

    // Write and read the entry storage
    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (ctl.rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Track written entries; reset marks all entries as cleared
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctl.wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (ctl.rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    // Unwritten entries read as zero
    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

    `PSLT_ASSERT_ALWAYS(a_no_rd_wr_overlap, !(ctl.rd_en && ctl.wr_en),
        "table read and write in the same cycle")
    `PSLT_ASSERT_NEXT(a_wr_sets_valid, ctl.wr_en, valid_reg[$past(wr_addr)],
        "written entry not marked valid")
    `PSLT_ASSERT_NEXT(a_rd_valid_follows, ctl.rd_en,
        rd_valid_reg == $past(valid_reg[rd_addr]) || $past(ctl.wr_en),
        "read valid flag does not match entry state")

endmodule

@@ hdl/per_sender_sequence_loss_tracker_top.sv @@
// Per-sender sequence loss tracker, top level.
//
// Channels: pkt takes one packet item (sender id, sequence number, optional
// sender timestamp, arrival time); res gives one result item per packet
// (gap class, missed counts, sent/received counters, latency, interval).
// Both use valid/ready; an item moves when valid and ready are high.
// An accepted packet is captured while its entry is read from the table; the
// update state then loads the output register and, for a sender in range,
// writes the entry back. A new packet is taken only after the last one has left the update state.
// pkt.ready is high in the idle state, also while a result waits in the
// output register; if res stalls, the next packet is held in the update
// state until the output register frees.
// Reset clears the global missed count and the per-entry valid bits, so every
// sender starts from an all-zero entry at once; no clearing pass is needed.
// A sender id at or above SENDERS leaves state untouched and gives a result
// of zeros except total_missed.
// Depends on pslt_pkg, pslt_ifs, pslt_table and the assertion macro header.
`include "per_sender_sequence_loss_tracker_top_assert.svh"

module per_sender_sequence_loss_tracker_top
    import pslt_pkg::*;
#(
    parameter int SENDERS = SENDERS_DEF
) (
    input logic         clk,
    input logic         rst_n,
    pslt_in_if.sink     pkt,
    pslt_out_if.source  res
);

    localparam int IDX_W = (SENDERS > 1) ? $clog2(SENDERS) : 1;
    localparam logic [ID_W:0] SENDERS_LIM = (ID_W + 1)'(SENDERS);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_CALC = 2'b10
    } state_t;

    state_t state_reg, state_next;

    // Captured packet
    logic [ID_W-1:0]   id_reg;
    logic [SEQ_W-1:0]  seq_reg;
    logic              stamp_reg;
    logic [TIME_W-1:0] sent_reg;
    logic [TIME_W-1:0] arr_reg;

    logic [CNT_W-1:0]  global_missed_reg, global_missed_next;

    // Output register
    logic                     res_valid_reg;
    gap_class_t               cls_reg, cls_next;
    logic [MISS_W-1:0]        missed_now_reg, missed_now_next;
    logic [MISS_W-1:0]        snd_missed_reg;
    logic [CNT_W-1:0]         snd_sent_reg;
    logic [CNT_W-1:0]         snd_rcv_reg;
    logic [CNT_W-1:0]         total_reg;
    logic                     lat_ok_reg, lat_ok_next;
    logic signed [TIME_W-1:0] lat_reg, lat_next;
    logic                     ipg_ok_reg, ipg_ok_next;
    logic [TIME_W-1:0]        ipg_reg, ipg_next;

    tbl_ctl_t            tbl_ctl;
    entry_t              ent, ent_new;
    logic                in_accept;
    logic                fire;
    logic                in_range;
    logic                later;
    logic [CNT_W-1:0]    rc_inc;
    logic [CNT_W-1:0]    ps_inc;
    logic signed [DIFF_W-1:0] diff;
    logic [MISS_W-1:0]   miss;

    assign pkt.ready = (state_reg == S_IDLE);
    assign in_accept = pkt.valid && pkt.ready;
    assign fire      = (state_reg == S_CALC) && (!res_valid_reg || res.ready);
    assign in_range  = ({1'b0, id_reg} < SENDERS_LIM);

    assign tbl_ctl.rd_en = in_accept;
    assign tbl_ctl.wr_en = fire && in_range;

    pslt_table #(
        .SENDERS (SENDERS)
    ) u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (tbl_ctl),
        .rd_addr (pkt.sender_id[IDX_W-1:0]),
        .wr_addr (id_reg[IDX_W-1:0]),
        .wr_data (ent_new),
        .rd_data (ent)
    );

    // Advance the sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = S_CALC;
                end
            end
            S_CALC:
            begin
                if (fire)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Classify the packet and build the updated entry
    always_comb
    begin
        rc_inc   = ent.rcv + 32'd1;
        ps_inc   = ent.sent + 32'd1;
        later    = (rc_inc > 32'd1);
        diff     = $signed({2'b00, seq_reg}) - $signed({2'b00, ent.last_seq})
                   - 18'sd1;
        ent_new  = ent;
        ent_new.rcv      = rc_inc;
        ent_new.sent     = ps_inc;
        ent_new.last_seq = seq_reg;
        miss     = '0;
        cls_next = CLS_FIRST;

        if (!later)
        begin
            ent_new.seq_start = seq_reg;
        end
        else if (!diff[DIFF_W-1])
        begin
            cls_next     = (diff == '0) ? CLS_INORDER : CLS_GAP;
            miss         = diff[MISS_W-1:0];
            ent_new.sent = ps_inc + {{(CNT_W - MISS_W){1'b0}}, diff[MISS_W-1:0]};
        end
        else if (diff == DIFF_DUP)
        begin
            cls_next     = CLS_DUP;
            miss         = 16'd1;
            ent_new.sent = ent.sent;
        end
        else if (diff < ROLL_LIMIT)
        begin
            // Wrap of the 16-bit sequence: missed is diff + 65536
            cls_next     = CLS_ROLL;
            miss         = diff[MISS_W-1:0];
            ent_new.sent = ps_inc + {{(CNT_W - MISS_W){1'b0}}, diff[MISS_W-1:0]};
        end
        else if (diff < RESTART_LIMIT)
        begin
            cls_next          = CLS_RESTART;
            miss              = 16'd1;
            ent_new.seq_start = seq_reg;
        end
        else
        begin
            // Out of order: missed is -(diff + 1)
            cls_next = CLS_OOO;
            miss     = ~diff[MISS_W-1:0];
        end

        ent_new.missed = ent.missed + miss;
        if (stamp_reg)
        begin
            ent_new.last_arrival = arr_reg;
        end
    end

    // Timing results and next output values
    always_comb
    begin
        missed_now_next    = miss;
        lat_ok_next        = stamp_reg;
        lat_next           = stamp_reg ? $signed(arr_reg - sent_reg) : '0;
        ipg_ok_next        = stamp_reg && later;
        ipg_next           = (stamp_reg && later) ? (arr_reg - ent.last_arrival) : '0;
        global_missed_next = global_missed_reg
                             + {{(CNT_W - MISS_W){1'b0}}, miss};
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            global_missed_reg <= '0;
            res_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (fire && in_range)
            begin
                global_missed_reg <= global_missed_next;
            end
            if (fire)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // Capture the accepted packet
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            id_reg    <= pkt.sender_id;
            seq_reg   <= pkt.seq_num;
            stamp_reg <= pkt.has_stamp;
            sent_reg  <= pkt.sent_time_us;
            arr_reg   <= pkt.arrival_time_us;
        end
    end

    // Load the output register
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            if (in_range)
            begin
                cls_reg        <= cls_next;
                missed_now_reg <= missed_now_next;
                snd_missed_reg <= ent_new.missed;
                snd_sent_reg   <= ent_new.sent;
                snd_rcv_reg    <= ent_new.rcv;
                total_reg      <= global_missed_next;
                lat_ok_reg     <= lat_ok_next;
                lat_reg        <= lat_next;
                ipg_ok_reg     <= ipg_ok_next;
                ipg_reg        <= ipg_next;
            end
            else
            begin
                // Drop: report only the global count
                cls_reg        <= CLS_FIRST;
                missed_now_reg <= '0;
                snd_missed_reg <= '0;
                snd_sent_reg   <= '0;
                snd_rcv_reg    <= '0;
                total_reg      <= global_missed_reg;
                lat_ok_reg     <= 1'b0;
                lat_reg        <= '0;
                ipg_ok_reg     <= 1'b0;
                ipg_reg        <= '0;
            end
        end
    end

    assign res.valid           = res_valid_reg;
    assign res.gap_class       = cls_reg;
    assign res.missed_now      = missed_now_reg;
    assign res.sender_missed   = snd_missed_reg;
    assign res.sender_sent     = snd_sent_reg;
    assign res.sender_received = snd_rcv_reg;
    assign res.total_missed    = total_reg;
    assign res.latency_valid   = lat_ok_reg;
    assign res.latency_us      = lat_reg;
    assign res.interval_valid  = ipg_ok_reg;
    assign res.interval_us     = ipg_reg;

    `PSLT_ASSERT_NEXT(a_accept_to_calc, in_accept, state_reg == S_CALC,
        "accepted item did not enter the update state")
    `PSLT_ASSERT_NEXT(a_fire_loads_result, fire, res_valid_reg && state_reg == S_IDLE,
        "finished item did not reach the output register")
    `PSLT_ASSERT_NEXT(a_global_only_on_fire, !(fire && in_range),
        $stable(global_missed_reg),
        "global missed count changed without an update")

endmodule

@@ verif/pslt_loss_predict_check.sv @@
// Result prediction and comparison for the per-sender sequence loss tracker.
// Watches the packet and result channels; depends on pslt_pkg and pslt_ifs.
module pslt_loss_predict_check
    import pslt_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    pslt_in_if   pkt,
    pslt_out_if  res,
    output int   errors,
    output int   pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        gap_class_t        cls;
        logic [MISS_W-1:0] missed_now;
        logic [MISS_W-1:0] sender_missed;
        logic [CNT_W-1:0]  sender_sent;
        logic [CNT_W-1:0]  sender_received;
        logic [CNT_W-1:0]  total_missed;
        logic              latency_valid;
        logic [TIME_W-1:0] latency;
        logic              interval_valid;
        logic [TIME_W-1:0] interval;
    } loss_result_t;

    // Per-sender counters and the loss total kept alongside the block
    logic [CNT_W-1:0]  rcv_cnt      [SENDERS_DEF];
    logic [CNT_W-1:0]  sent_cnt     [SENDERS_DEF];
    logic [SEQ_W-1:0]  last_seq     [SENDERS_DEF];
    logic [MISS_W-1:0] missed_cnt   [SENDERS_DEF];
    logic [TIME_W-1:0] last_arr     [SENDERS_DEF];
    logic [CNT_W-1:0]  lost_total;

    loss_result_t      predicted_results [$];
    loss_result_t      want;
    int                mismatches;

    // Class one packet against its sender's history and update the counters
    function automatic loss_result_t track_packet(
        input logic [ID_W-1:0]   id,
        input logic [SEQ_W-1:0]  seq,
        input logic              stamped,
        input logic [TIME_W-1:0] sent_t,
        input logic [TIME_W-1:0] arr_t
    );
        loss_result_t     r;
        int               d;
        logic [CNT_W-1:0] miss;
        logic             later;
        r = '0;
        miss = '0;
        r.cls = CLS_FIRST;
        rcv_cnt[id] = rcv_cnt[id] + 1;
        sent_cnt[id] = sent_cnt[id] + 1;
        later = (rcv_cnt[id] > 1);
        if (later)
        begin
            d = int'(seq) - int'(last_seq[id]) - 1;
            if (d >= 0)
            begin
                r.cls = (d == 0) ? CLS_INORDER : CLS_GAP;
                miss = d;
                sent_cnt[id] = sent_cnt[id] + miss;
            end
            else if (d == int'(DIFF_DUP))
            begin
                r.cls = CLS_DUP;
                miss = 1;
                sent_cnt[id] = sent_cnt[id] - 1;
            end
            else if (d < int'(ROLL_LIMIT))
            begin
                // sequence wrapped past 16 bits; the count may come out zero
                r.cls = CLS_ROLL;
                miss = int'(seq) + 65535 - int'(last_seq[id]);
                sent_cnt[id] = sent_cnt[id] + miss;
            end
            else if (d < int'(RESTART_LIMIT))
            begin
                r.cls = CLS_RESTART;
                miss = 1;
            end
            else
            begin
                r.cls = CLS_OOO;
                miss = -(d + 1);
            end
            missed_cnt[id] = missed_cnt[id] + miss[MISS_W-1:0];
            lost_total = lost_total + miss;
        end
        last_seq[id] = seq;

        // Latency and inter-arrival interval only for stamped packets
        if (stamped)
        begin
            r.latency_valid = 1'b1;
            r.latency = arr_t - sent_t;
            if (later)
            begin
                r.interval_valid = 1'b1;
                r.interval = arr_t - last_arr[id];
            end
            last_arr[id] = arr_t;
        end

        r.missed_now = miss[MISS_W-1:0];
        r.sender_missed = missed_cnt[id];
        r.sender_sent = sent_cnt[id];
        r.sender_received = rcv_cnt[id];
        r.total_missed = lost_total;
        return r;
    endfunction

    task automatic compare_field(input string name, input logic [63:0] exp_v,
                                 input logic [63:0] act_v);
        if (act_v !== exp_v)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: %s mismatch, expected %0h, got %0h",
                         $time, name, exp_v, act_v);
        end
    endtask

    // Predict on each accepted packet, compare on each accepted result
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SENDERS_DEF; i++)
            begin
                rcv_cnt[i] = '0;
                sent_cnt[i] = '0;
                last_seq[i] = '0;
                missed_cnt[i] = '0;
                last_arr[i] = '0;
            end
            lost_total = '0;
            predicted_results.delete();
            mismatches = 0;
            errors <= 0;
            pending <= 0;
        end
        else
        begin
            if (pkt.valid && pkt.ready)
                predicted_results.push_back(track_packet(pkt.sender_id, pkt.seq_num,
                    pkt.has_stamp, pkt.sent_time_us, pkt.arrival_time_us));
            if (res.valid && res.ready)
            begin
                if (predicted_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: result item with no packet waiting", $time);
                end
                else
                begin
                    want = predicted_results.pop_front();
                    compare_field("gap_class", 64'(want.cls), 64'(res.gap_class));
                    compare_field("missed_now", 64'(want.missed_now),
                                  64'(res.missed_now));
                    compare_field("sender_missed", 64'(want.sender_missed),
                                  64'(res.sender_missed));
                    compare_field("sender_sent", 64'(want.sender_sent),
                                  64'(res.sender_sent));
                    compare_field("sender_received", 64'(want.sender_received),
                                  64'(res.sender_received));
                    compare_field("total_missed", 64'(want.total_missed),
                                  64'(res.total_missed));
                    compare_field("latency_valid", 64'(want.latency_valid),
                                  64'(res.latency_valid));
                    compare_field("latency_us", want.latency, res.latency_us);
                    compare_field("interval_valid", 64'(want.interval_valid),
                                  64'(res.interval_valid));
                    compare_field("interval_us", want.interval, res.interval_us);
                end
            end
            errors <= mismatches;
            pending <= predicted_results.size();
        end
    end

endmodule

@@ verif/tb_per_sender_sequence_loss_tracker_top.sv @@
// Testbench top for the per-sender sequence loss tracker: clock, reset,
// packet stimulus, result back-pressure and the verdict.
// Depends on pslt_pkg, pslt_ifs, the tracker RTL and pslt_loss_predict_check.
module tb_per_sender_sequence_loss_tracker_top;
    timeunit 1ns;
    timeprecision 1ps;
    import pslt_pkg::*;

    logic              clk = 1'b0;
    logic              rst_n;
    int                errors;
    int                pending;
    bit                quiet;
    bit                long_hold_req;
    logic [TIME_W-1:0] now_us;
    logic [SEQ_W-1:0]  prev_seq [SENDERS_DEF];
    logic [ID_W-1:0]   busy_ids [8];

    pslt_in_if  pkt_ch();
    pslt_out_if res_ch();

    per_sender_sequence_loss_tracker_top #(
        .SENDERS (SENDERS_DEF)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .pkt   (pkt_ch),
        .res   (res_ch)
    );

    pslt_loss_predict_check loss_chk (
        .clk     (clk),
        .rst_n   (rst_n),
        .pkt     (pkt_ch),
        .res     (res_ch),
        .errors  (errors),
        .pending (pending)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Offer one packet, with an occasional idle burst ahead of it
    task automatic send_packet(
        input logic [ID_W-1:0]   id,
        input logic [SEQ_W-1:0]  seq,
        input logic              stamped,
        input logic [TIME_W-1:0] sent_t,
        input logic [TIME_W-1:0] arr_t
    );
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            pkt_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        pkt_ch.valid <= 1'b1;
        pkt_ch.sender_id <= id;
        pkt_ch.seq_num <= seq;
        pkt_ch.has_stamp <= stamped;
        pkt_ch.sent_time_us <= sent_t;
        pkt_ch.arrival_time_us <= arr_t;
        do @(posedge clk); while (!pkt_ch.ready);
        prev_seq[id] = seq;
    endtask

    // Mostly plausible sequence moves on a few busy senders, some noise
    task automatic send_random_packet();
        logic [ID_W-1:0]   id;
        logic [SEQ_W-1:0]  last;
        logic [SEQ_W-1:0]  seq;
        logic              stamped;
        logic [TIME_W-1:0] sent_t;
        logic [TIME_W-1:0] arr_t;
        int                pick;
        int                k;
        int                hi;
        id = ($urandom_range(0, 9) == 0) ? ID_W'($urandom) : busy_ids[$urandom_range(0, 7)];
        last = prev_seq[id];
        pick = $urandom_range(0, 99);
        if (pick < 55)
            seq = last + SEQ_W'(1);
        else if (pick < 65)
            seq = last + SEQ_W'(1)
                  + SEQ_W'(($urandom_range(0, 3) == 0) ? $urandom_range(1, 65534)
                                                        : $urandom_range(1, 30));
        else if (pick < 70)
            seq = last;
        else if (pick < 78)
            seq = last - SEQ_W'($urandom_range(1, 19));
        else if (pick < 84)
        begin
            k = $urandom_range(20, 32767);
            seq = last - SEQ_W'(k);
        end
        else if (pick < 92)
        begin
            // wrap below the last value, or climb near the top first
            if (last >= 32768)
            begin
                hi = int'(last) - 32768;
                if ($urandom_range(0, 1) == 0 && hi > 40)
                    hi = 40;
                seq = SEQ_W'($urandom_range(0, hi));
            end
            else
                seq = SEQ_W'($urandom_range(60000, 65535));
        end
        else
            seq = SEQ_W'($urandom);

        now_us = now_us + TIME_W'($urandom_range(1, 5000));
        arr_t = now_us;
        stamped = ($urandom_range(0, 4) != 0);
        pick = $urandom_range(0, 19);
        if (pick == 0)
        begin
            arr_t = {$urandom, $urandom};
            sent_t = {$urandom, $urandom};
        end
        else if (pick == 1)
            sent_t = arr_t + TIME_W'($urandom_range(1, 2000));
        else
            sent_t = arr_t - TIME_W'($urandom_range(0, 3000));
        if (!stamped)
            sent_t = {$urandom, $urandom};
        send_packet(id, seq, stamped, sent_t, arr_t);
    endtask

    // Hold until every predicted result has been taken
    task automatic wait_drained();
        do @(posedge clk); while (pending != 0);
    endtask

    // Result side: random stall bursts, one long hold on request
    initial
    begin
        res_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                res_ch.ready <= 1'b0;
                repeat (400) @(posedge clk);
            end
            else if (!quiet && $urandom_range(0, 3) == 0)
            begin
                res_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
            else
            begin
                res_ch.ready <= 1'b1;
                repeat (quiet ? 1 : $urandom_range(1, 30)) @(posedge clk);
            end
        end
    end

    // Packet stimulus and verdict
    initial
    begin
        rst_n <= 1'b0;
        pkt_ch.valid <= 1'b0;
        pkt_ch.sender_id <= '0;
        pkt_ch.seq_num <= '0;
        pkt_ch.has_stamp <= 1'b0;
        pkt_ch.sent_time_us <= '0;
        pkt_ch.arrival_time_us <= '0;
        quiet = 1'b0;
        long_hold_req = 1'b0;
        now_us = {24'h0, $urandom, 8'h0};
        for (int i = 0; i < SENDERS_DEF; i++)
            prev_seq[i] = '0;
        busy_ids[0] = 8'd0;
        busy_ids[1] = 8'd255;
        for (int i = 2; i < 8; i++)
            busy_ids[i] = ID_W'($urandom);
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // sender 0: first, in order with negative latency, wide gap,
        // duplicate with wrapped times, rollover losing nothing, gap, out of order
        send_packet(8'd0, 16'd0, 1'b1, 64'd0, 64'd100);
        send_packet(8'd0, 16'd1, 1'b1, 64'd200, 64'd150);
        send_packet(8'd0, 16'd65535, 1'b0, 64'd0, 64'd400);
        send_packet(8'd0, 16'd65535, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 64'd0);
        send_packet(8'd0, 16'd0, 1'b0, 64'd0, 64'd500);
        send_packet(8'd0, 16'd9, 1'b0, 64'd0, 64'd600);
        send_packet(8'd0, 16'd7, 1'b0, 64'd0, 64'd700);
        // sender 255: restart and out-of-order edges, restart at the rollover
        // edge, largest rollover loss, extreme latency and interval
        send_packet(8'd255, 16'd65535, 1'b0, 64'd0, 64'd0);
        send_packet(8'd255, 16'd65515, 1'b0, 64'd0, 64'd0);
        send_packet(8'd255, 16'd65496, 1'b0, 64'd0, 64'd0);
        send_packet(8'd255, 16'd65495, 1'b0, 64'd0, 64'd0);
        send_packet(8'd255, 16'd32728, 1'b0, 64'd0, 64'd0);
        send_packet(8'd255, 16'd65495, 1'b0, 64'd0, 64'd0);
        send_packet(8'd255, 16'd32727, 1'b0, 64'd0, 64'd0);
        send_packet(8'd255, 16'd32728, 1'b1, 64'd0, 64'hFFFF_FFFF_FFFF_FFFF);
        send_packet(8'd255, 16'd32729, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 64'd0);
        // full-range gap, duplicate right after a first, stamped first
        send_packet(8'd3, 16'd0, 1'b0, 64'd0, 64'd0);
        send_packet(8'd3, 16'd65535, 1'b1, 64'd10, 64'd20);
        send_packet(8'd1, 16'd0, 1'b0, 64'd0, 64'd0);
        send_packet(8'd1, 16'd0, 1'b0, 64'd0, 64'd0);
        send_packet(8'd128, 16'd12345, 1'b1, 64'd5, 64'd3);
        send_packet(8'hAA, 16'hAAAA, 1'b1, 64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555);
        send_packet(8'h55, 16'h5555, 1'b1, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);
        pkt_ch.valid <= 1'b0;
        wait_drained();

        // random traffic: long result hold, a full drain, then no idling
        for (int n = 0; n < 2000; n++)
        begin
            if (n == 600)
                long_hold_req = 1'b1;
            if (n == 1000)
            begin
                pkt_ch.valid <= 1'b0;
                wait_drained();
            end
            if (n == 1700)
                quiet = 1'b1;
            send_random_packet();
        end
        pkt_ch.valid <= 1'b0;
        wait_drained();
        repeat (10) @(posedge clk);

        if (errors == 0 && pending == 0)
            $display("tb_per_sender_sequence_loss_tracker_top: done, clean");
        else
            $display("tb_per_sender_sequence_loss_tracker_top: done, errors");
        $finish;
    end

    // Give up on a hang
    initial
    begin
        #20_000_000;
        $display("tb_per_sender_sequence_loss_tracker_top: done, errors");
        $finish;
    end

endmodule
